[rtl/core/rbf_pkg.sv]
// ring buffer fifo package: field widths, operation codes, controller states
// and the result record handed from the controller to the output register
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rbf_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned OP_W          = 3;
  localparam int unsigned LEN_W         = 7;
  localparam int unsigned COUNT_W       = 6;
  localparam int unsigned LEN_RESET     = 64;
  localparam int unsigned LEN_MIN       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUT      = 3'd0,
    OP_GET      = 3'd1,
    OP_PEEK     = 3'd2,
    OP_PEEK_ALL = 3'd3,
    OP_FLUSH    = 3'd4,
    OP_DISCARD  = 3'd5
  } rbf_op_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } rbf_state_e;

  typedef struct packed {
    logic [DATA_W-1:0]  data;
    logic               valid_res;
    logic               last;
    logic               dropped;
    logic [COUNT_W-1:0] count;
    logic               full_res;
    logic               empty_res;
  } rbf_res_t;

endpackage

`default_nettype wire

[rtl/core/rbf_ram.sv]
// ring buffer fifo word store: one write port, one read port, registered read
// depends on rbf_pkg
`timescale 1ns / 1ps
`default_nettype none

module rbf_ram
  import rbf_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = DEPTH_DEFAULT,
  localparam int unsigned IDX_W = $clog2(BUFFER_DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [IDX_W-1:0]  waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [IDX_W-1:0]  raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [BUFFER_DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/rbf_ctrl.sv]
// ring buffer fifo controller: indices, ring length, operation decode and
// the read sequencer for get, peek and dumps
// depends on rbf_pkg
`timescale 1ns / 1ps
`default_nettype none

module rbf_ctrl
  import rbf_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = DEPTH_DEFAULT,
  localparam int unsigned IDX_W = $clog2(BUFFER_DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              ring_length_we_i,
  input  wire logic [LEN_W-1:0]  ring_length_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [OP_W-1:0]   op_i,
  input  wire logic [DATA_W-1:0] value_i,
  input  wire logic              slot_free_i,
  output logic                   res_valid_o,
  output rbf_res_t               res_o,
  output logic                   we_o,
  output logic      [IDX_W-1:0]  waddr_o,
  output logic      [DATA_W-1:0] wdata_o,
  output logic                   re_o,
  output logic      [IDX_W-1:0]  raddr_o,
  input  wire logic [DATA_W-1:0] rdata_i
);

  localparam logic [LEN_W-1:0] LenMax = LEN_W'(BUFFER_DEPTH);
  localparam logic [LEN_W-1:0] LenMin = LEN_W'(LEN_MIN);

  rbf_state_e       state_q, state_d;
  logic [IDX_W-1:0] rd_q, rd_d;
  logic [IDX_W-1:0] wr_q, wr_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [IDX_W-1:0] rem_q, rem_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             consume_q, consume_d;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] r;
    r = n;
    if (r < LenMin) r = LenMin;
    if (r > LenMax) r = LenMax;
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                               input logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] nxt;
    nxt = LEN_W'(idx) + LEN_W'(1);
    return (nxt >= n) ? '0 : nxt[IDX_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] ring_count(input logic [IDX_W-1:0] w,
                                                  input logic [IDX_W-1:0] r,
                                                  input logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] c;
    if (w >= r) c = LEN_W'(w) - LEN_W'(r);
    else        c = n - (LEN_W'(r) - LEN_W'(w));
    return c;
  endfunction

  logic             accept;
  logic             empty_now;
  logic             full_now;
  logic [IDX_W-1:0] pos_next;
  logic [LEN_W-1:0] cnt_after;
  logic [LEN_W-1:0] cnt_now;
  logic [DATA_W-1:0] res_data;
  logic             res_vld;
  logic             res_last;
  logic             res_drop;

  assign in_ready_o = (state_q == ST_IDLE) && slot_free_i && !ring_length_we_i;
  assign accept     = in_valid_i && in_ready_o;
  assign empty_now  = (rd_q == wr_q);
  assign full_now   = (advance(wr_q, len_q) == rd_q);
  assign pos_next   = advance(pos_q, len_q);
  assign cnt_now    = ring_count(wr_q, rd_q, len_q);

  always_comb begin
    state_d     = state_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    pos_d       = pos_q;
    rem_d       = rem_q;
    len_d       = len_q;
    consume_d   = consume_q;
    we_o        = 1'b0;
    re_o        = 1'b0;
    raddr_o     = rd_q;
    res_valid_o = 1'b0;
    res_data    = '0;
    res_vld     = 1'b0;
    res_last    = 1'b1;
    res_drop    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (ring_length_we_i) begin
          len_d = clamp_len(ring_length_i);
          rd_d  = '0;
          wr_d  = '0;
        end else if (accept) begin
          unique case (rbf_op_e'(op_i))
            OP_PUT: begin
              res_valid_o = 1'b1;
              res_drop    = full_now;
              if (!full_now) begin
                we_o = 1'b1;
                wr_d = advance(wr_q, len_q);
              end
            end
            OP_GET, OP_PEEK: begin
              if (empty_now) begin
                res_valid_o = 1'b1;
              end else begin
                re_o      = 1'b1;
                pos_d     = rd_q;
                rem_d     = IDX_W'(1);
                consume_d = (rbf_op_e'(op_i) == OP_GET);
                state_d   = ST_READ;
              end
            end
            OP_PEEK_ALL, OP_FLUSH: begin
              if (empty_now) begin
                res_valid_o = 1'b1;
              end else begin
                re_o      = 1'b1;
                pos_d     = rd_q;
                rem_d     = cnt_now[IDX_W-1:0];
                consume_d = (rbf_op_e'(op_i) == OP_FLUSH);
                state_d   = ST_READ;
              end
            end
            OP_DISCARD: begin
              res_valid_o = 1'b1;
              rd_d        = wr_q;
            end
            default: begin
              res_valid_o = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        if (slot_free_i) begin
          res_valid_o = 1'b1;
          res_data    = rdata_i;
          res_vld     = 1'b1;
          res_last    = (rem_q == IDX_W'(1));
          if (consume_q) begin
            rd_d = pos_next;
          end
          if (rem_q == IDX_W'(1)) begin
            state_d = ST_IDLE;
          end else begin
            re_o    = 1'b1;
            raddr_o = pos_next;
            pos_d   = pos_next;
            rem_d   = rem_q - IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign waddr_o   = wr_q;
  assign wdata_o   = value_i;
  assign cnt_after = ring_count(wr_d, rd_d, len_q);

  always_comb begin
    res_o.data      = res_data;
    res_o.valid_res = res_vld;
    res_o.last      = res_last;
    res_o.dropped   = res_drop;
    res_o.count     = cnt_after[COUNT_W-1:0];
    res_o.full_res  = (cnt_after == len_q - LEN_W'(1));
    res_o.empty_res = (rd_d == wr_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_q      <= '0;
      wr_q      <= '0;
      pos_q     <= '0;
      rem_q     <= '0;
      len_q     <= clamp_len(LEN_W'(LEN_RESET));
      consume_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_q      <= rd_d;
      wr_q      <= wr_d;
      pos_q     <= pos_d;
      rem_q     <= rem_d;
      len_q     <= len_d;
      consume_q <= consume_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ring_buffer_fifo_core.sv]
// ring buffer fifo top level: controller, word store and output register
// depends on rbf_pkg, rbf_ram, rbf_ctrl
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_ready_o    op_i, value_i
//   out       output     out_valid_o / out_ready_i  data_o .. empty_res_o
//   config    input      ring_length_we_i           ring_length_i
//
// put, discard and empty-ring reads are answered straight from the idle state
// get and peek one pass through the read state for the synchronous store read
// peek all and flush stay in the read state for one result per stored word
// the output register frees the input side as soon as out_ready_i is high
// reset empties the ring and sets the length to its maximum; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module ring_buffer_fifo_core
  import rbf_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               ring_length_we_i,
  input  wire logic [LEN_W-1:0]   ring_length_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [OP_W-1:0]    op_i,
  input  wire logic [DATA_W-1:0]  value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [DATA_W-1:0]  data_o,
  output logic                    valid_res_o,
  output logic                    last_o,
  output logic                    dropped_o,
  output logic      [COUNT_W-1:0] count_o,
  output logic                    full_res_o,
  output logic                    empty_res_o
);

  localparam int unsigned IDX_W = $clog2(BUFFER_DEPTH);

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] wdata;
  logic              re;
  logic [IDX_W-1:0]  raddr;
  logic [DATA_W-1:0] rdata;
  logic              slot_free;
  logic              res_valid;
  rbf_res_t          res;
  rbf_res_t          out_q;
  logic              out_valid_q, out_valid_d;

  rbf_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ring_length_we_i(ring_length_we_i),
    .ring_length_i   (ring_length_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .value_i         (value_i),
    .slot_free_i     (slot_free),
    .res_valid_o     (res_valid),
    .res_o           (res),
    .we_o            (we),
    .waddr_o         (waddr),
    .wdata_o         (wdata),
    .re_o            (re),
    .raddr_o         (raddr),
    .rdata_i         (rdata)
  );

  rbf_ram #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_d = res_valid || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = out_q.data;
  assign valid_res_o = out_q.valid_res;
  assign last_o      = out_q.last;
  assign dropped_o   = out_q.dropped;
  assign count_o     = out_q.count;
  assign full_res_o  = out_q.full_res;
  assign empty_res_o = out_q.empty_res;

endmodule

`default_nettype wire
